### src/hlpi_pkg.sv
// Shared types, constants and trig tables for the Hough line intersection block.
`timescale 1ns / 1ps

package hlpi_pkg;

    // Angle resolution and output fraction bits.
    localparam int ANGLE_STEPS = 180;
    localparam int FRAC_BITS   = 4;

    // Store geometry.
    localparam int STORE_DEPTH = 64;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;

    // Field widths.
    localparam int RHO_W   = 12;
    localparam int ANGLE_W = 8;
    localparam int TRIG_W  = 17;
    localparam int DIM_W   = 11;
    localparam int THR_W   = 15;
    localparam int COORD_W = 15;
    localparam int LIM_W   = DIM_W + FRAC_BITS;

    // Datapath widths.
    localparam int DPROD_W = 2 * TRIG_W;
    localparam int DET_W   = DPROD_W + 1;
    localparam int DMAG_W  = DPROD_W;
    localparam int NPROD_W = TRIG_W + RHO_W;
    localparam int NUM_W   = NPROD_W + 1;
    localparam int NMAG_W  = NPROD_W;
    localparam int SHIFT   = 15 + FRAC_BITS;
    localparam int DIVN_W  = NMAG_W + SHIFT + 1;
    localparam int QUOT_W  = 17;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 15;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_THRESH = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } seq_state_t;

    typedef logic signed [RHO_W-1:0]  rho_t;
    typedef logic [ANGLE_W-1:0]       angle_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic signed [TRIG_W-1:0] trig_t;
    typedef trig_t trig_tab_t [256];

    // One pair moving down the pipeline.
    typedef struct packed {
        logic valid;
        idx_t j;
        idx_t me;
        logic fin;
    } tok_t;

    // Pair control plus the outcome of the determinant checks.
    typedef struct packed {
        tok_t tok;
        logic ok;
        logic neg_x;
        logic neg_y;
    } flag_t;

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;

    // One Horner step of the series; divisors are fixed per step.
    function automatic logic [63:0] horner(input logic [63:0] x2, input logic [63:0] t,
                                           input int step, input logic is_cos);
        logic [63:0] m;
        logic [63:0] p;
        m = (x2 * t) >> 30;
        if (!is_cos) begin
            case (step)
                0: p = m / 64'd110;
                1: p = m / 64'd72;
                2: p = m / 64'd42;
                3: p = m / 64'd20;
                default: p = m / 64'd6;
            endcase
        end else begin
            case (step)
                0: p = m / 64'd132;
                1: p = m / 64'd90;
                2: p = m / 64'd56;
                3: p = m / 64'd30;
                4: p = m / 64'd12;
                default: p = m / 64'd2;
            endcase
        end
        return (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
    endfunction

    // Round Q30 to Q15 with saturation at one.
    function automatic logic [TRIG_W-1:0] q30_to_q15(input logic [63:0] v);
        logic [63:0] r;
        r = (v + 64'd16384) >> 15;
        if (r > 64'd32768)
            r = 64'd32768;
        return r[TRIG_W-1:0];
    endfunction

    // Sine in the upper half, cosine in the lower half.
    function automatic logic [2*TRIG_W-1:0] make_trig(input int idx);
        int          k;
        logic        flip;
        logic        mirror;
        logic [63:0] x30;
        logic [63:0] x2;
        logic [63:0] t;
        logic [TRIG_W-1:0] s;
        logic [TRIG_W-1:0] c;
        k      = idx % ANGLE_STEPS;
        flip   = ((idx / ANGLE_STEPS) % 2) == 1;
        mirror = (2 * k) > ANGLE_STEPS;
        if (mirror)
            k = ANGLE_STEPS - k;
        x30 = (64'(k) * PI_Q30 + 64'(ANGLE_STEPS / 2)) / 64'(ANGLE_STEPS);
        x2  = (x30 * x30) >> 30;
        t = Q30_ONE;
        for (int i = 0; i < 5; i++)
            t = horner(x2, t, i, 1'b0);
        s = q30_to_q15((x30 * t) >> 30);
        t = Q30_ONE;
        for (int i = 0; i < 6; i++)
            t = horner(x2, t, i, 1'b1);
        c = q30_to_q15(t);
        if (mirror)
            c = -c;
        if (flip) begin
            s = -s;
            c = -c;
        end
        return {s, c};
    endfunction

    function automatic trig_tab_t build_sin_tab();
        trig_tab_t tab;
        logic [2*TRIG_W-1:0] sc;
        for (int i = 0; i < 256; i++) begin
            sc = make_trig(i);
            tab[i] = sc[2*TRIG_W-1:TRIG_W];
        end
        return tab;
    endfunction

    function automatic trig_tab_t build_cos_tab();
        trig_tab_t tab;
        logic [2*TRIG_W-1:0] sc;
        for (int i = 0; i < 256; i++) begin
            sc = make_trig(i);
            tab[i] = sc[TRIG_W-1:0];
        end
        return tab;
    endfunction

    localparam trig_tab_t SIN_TAB = build_sin_tab();
    localparam trig_tab_t COS_TAB = build_cos_tab();

endpackage

### src/hlpi_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module hlpi_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read; data holds while the read is disabled.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/hlpi_div.sv
// Pipelined restoring divider: one quotient bit per stage, with overflow detect.
`timescale 1ns / 1ps

module hlpi_div #(
    parameter int NW = 49,
    parameter int DW = 34,
    parameter int QW = 17
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quot,
    output logic          ovf
);

    localparam int CW = ((NW > DW + QW) ? NW : DW + QW) + 1;

    logic [NW-1:0] rem_reg [QW];
    logic [QW-1:0] q_reg   [QW];
    logic [DW-1:0] d_reg   [QW];
    logic          ov_reg  [QW];

    for (genvar g = 0; g < QW; g++)
    begin : g_stage
        logic [NW-1:0] rem_in;
        logic [QW-1:0] q_in;
        logic [DW-1:0] d_in;
        logic          ov_in;
        logic [CW-1:0] trial;
        logic          take;

        // Stage inputs: ports for the first stage, previous stage otherwise.
        if (g == 0)
        begin : g_first
            assign rem_in = num;
            assign q_in   = '0;
            assign d_in   = den;
            assign ov_in  = CW'(num) >= (CW'(den) << QW);
        end
        else
        begin : g_next
            assign rem_in = rem_reg[g-1];
            assign q_in   = q_reg[g-1];
            assign d_in   = d_reg[g-1];
            assign ov_in  = ov_reg[g-1];
        end

        // Trial subtract for this quotient bit.
        assign trial = CW'(d_in) << (QW - 1 - g);
        assign take  = CW'(rem_in) >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g] <= take ? NW'(CW'(rem_in) - trial) : rem_in;
                q_reg[g]   <= take ? (q_in | (QW'(1) << (QW - 1 - g))) : q_in;
                d_reg[g]   <= d_in;
                ov_reg[g]  <= ov_in;
            end
        end
    end

    assign quot = q_reg[QW-1];
    assign ovf  = ov_reg[QW-1];

endmodule

### src/hlpi_front.sv
// Pair front end: trig lookup, products, determinant and divider operands.
`timescale 1ns / 1ps

module hlpi_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  hlpi_pkg::tok_t      tok_in,
    input  hlpi_pkg::trig_t     s2_in,
    input  hlpi_pkg::trig_t     c2_in,
    input  hlpi_pkg::rho_t      r2_in,
    input  hlpi_pkg::rho_t      mem_rho,
    input  hlpi_pkg::angle_t    mem_angle,
    input  logic [hlpi_pkg::THR_W-1:0]  thr,
    output hlpi_pkg::flag_t     flags,
    output logic [hlpi_pkg::DMAG_W-1:0] den,
    output logic [hlpi_pkg::DIVN_W-1:0] num_x,
    output logic [hlpi_pkg::DIVN_W-1:0] num_y
);

    import hlpi_pkg::*;

    tok_t tok1_reg, tok2_reg, tok3_reg;
    flag_t flags_reg;

    trig_t s1_reg, c1_reg, s2_1_reg, c2_1_reg;
    rho_t  r1_reg, r2_1_reg;

    logic signed [DPROD_W-1:0] p_cs_reg, p_sc_reg;
    logic signed [NPROD_W-1:0] px1_reg, px2_reg, py1_reg, py2_reg;

    logic signed [DET_W-1:0] d_reg;
    logic signed [NUM_W-1:0] nx_reg, ny_reg;

    logic [DMAG_W-1:0] magd;
    logic [NMAG_W-1:0] magx, magy;
    logic [DMAG_W-1:0] den_reg;
    logic [DIVN_W-1:0] num_x_reg, num_y_reg;

    // Control tokens follow the data stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok1_reg  <= '0;
            tok2_reg  <= '0;
            tok3_reg  <= '0;
            flags_reg <= '0;
        end
        else if (en)
        begin
            tok1_reg        <= tok_in;
            tok2_reg        <= tok1_reg;
            tok3_reg        <= tok2_reg;
            flags_reg.tok   <= tok3_reg;
            flags_reg.ok    <= (d_reg != '0) && (magd >= (DMAG_W'(thr) << 15));
            flags_reg.neg_x <= nx_reg[NUM_W-1] ^ d_reg[DET_W-1];
            flags_reg.neg_y <= ny_reg[NUM_W-1] ^ d_reg[DET_W-1];
        end
    end

    // Magnitudes of the determinant and the numerators.
    assign magd = d_reg[DET_W-1] ? DMAG_W'(-d_reg) : DMAG_W'(d_reg);
    assign magx = nx_reg[NUM_W-1] ? NMAG_W'(-nx_reg) : NMAG_W'(nx_reg);
    assign magy = ny_reg[NUM_W-1] ? NMAG_W'(-ny_reg) : NMAG_W'(ny_reg);

    // Data stages: lookup, multiply, subtract, operand build.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg   <= SIN_TAB[mem_angle];
            c1_reg   <= COS_TAB[mem_angle];
            r1_reg   <= mem_rho;
            s2_1_reg <= s2_in;
            c2_1_reg <= c2_in;
            r2_1_reg <= r2_in;

            p_cs_reg <= DPROD_W'(c1_reg) * DPROD_W'(s2_1_reg);
            p_sc_reg <= DPROD_W'(s1_reg) * DPROD_W'(c2_1_reg);
            px1_reg  <= NPROD_W'(s2_1_reg) * NPROD_W'(r1_reg);
            px2_reg  <= NPROD_W'(s1_reg) * NPROD_W'(r2_1_reg);
            py1_reg  <= NPROD_W'(c1_reg) * NPROD_W'(r2_1_reg);
            py2_reg  <= NPROD_W'(c2_1_reg) * NPROD_W'(r1_reg);

            d_reg  <= DET_W'(p_cs_reg) - DET_W'(p_sc_reg);
            nx_reg <= NUM_W'(px1_reg) - NUM_W'(px2_reg);
            ny_reg <= NUM_W'(py1_reg) - NUM_W'(py2_reg);

            den_reg   <= magd;
            num_x_reg <= (DIVN_W'(magx) << SHIFT) + DIVN_W'(magd >> 1);
            num_y_reg <= (DIVN_W'(magy) << SHIFT) + DIVN_W'(magd >> 1);
        end
    end

    assign flags = flags_reg;
    assign den   = den_reg;
    assign num_x = num_x_reg;
    assign num_y = num_y_reg;

endmodule

### src/hough_line_pair_intersection_core.sv
// Top level: line store, pair sequencer, dividers and result output stage.
`timescale 1ns / 1ps

// Hough line pair intersection core.
// Input channel (in_valid/in_ready) takes one line word: first_line, rho,
// theta_index. The new line is written at the next store index of a 64-entry
// line memory when it is taken; each earlier stored line of the frame is then
// read back and paired with it. Output channel (out_valid/out_ready) gives
// one word per surviving intersection, grouped by the new line, with last
// set on the final word that the line causes.
// Throughput: a line with N stored predecessors holds the sequencer while
// its N pairs issue, one per cycle unless the output stalls.
// No new line is taken meanwhile. A pair's word passes the memory read, four
// arithmetic stages, a 17-stage divider, a hold stage and the output register.
// Configuration writes go through cfg_we/cfg_index/cfg_data; the user must
// make them only while idle, the block itself does not enforce this. Reset
// empties the store, loads 640 x 480 bounds and threshold 1638; the memory
// needs no clearing pass. When the receiver stalls, the whole pair pipeline
// freezes and no new line is taken until it drains forward.
module hough_line_pair_intersection_core #(
    parameter int MAX_LINES = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [hlpi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hlpi_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                first_line,
    input  logic signed [hlpi_pkg::RHO_W-1:0]   rho,
    input  logic [hlpi_pkg::ANGLE_W-1:0]        theta_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [hlpi_pkg::COORD_W-1:0]        x_q4,
    output logic [hlpi_pkg::COORD_W-1:0]        y_q4,
    output logic [hlpi_pkg::IDX_W-1:0]          earlier_line,
    output logic [hlpi_pkg::IDX_W-1:0]          later_line,
    output logic                                last
);

    import hlpi_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LINES);
    localparam int MEM_W = RHO_W + ANGLE_W;

    // Configuration registers.
    logic [DIM_W-1:0] width_reg, height_reg;
    logic [THR_W-1:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(640);
            height_reg <= DIM_W'(480);
            thr_reg    <= THR_W'(1638);
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                CFG_THRESH: thr_reg    <= cfg_data[THR_W-1:0];
                default:    ;
            endcase
        end
    end

    // Pipeline advance: everything moves when the output slot is free.
    logic out_valid_reg;
    logic adv;
    assign adv = !out_valid_reg || out_ready;

    // Sequencer state.
    seq_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    idx_t j_reg, j_next, me_reg, me_next;
    trig_t s2_reg, c2_reg;
    rho_t  r2_reg;
    logic [CNT_W-1:0] base;
    logic accept, mem_we;
    tok_t issue_tok;

    assign accept = in_valid && in_ready;
    assign base   = first_line ? '0 : cnt_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        j_next     = j_reg;
        me_next    = me_reg;
        mem_we     = 1'b0;
        in_ready   = 1'b0;
        issue_tok  = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = adv;
                if (accept)
                begin
                    if (base < MAX_CNT)
                    begin
                        mem_we   = 1'b1;
                        cnt_next = base + CNT_W'(1);
                        if (base != '0)
                        begin
                            me_next    = base[IDX_W-1:0];
                            j_next     = '0;
                            state_next = ST_RUN;
                        end
                    end
                    else
                    begin
                        cnt_next = base;
                    end
                end
            end
            ST_RUN:
            begin
                issue_tok.valid = 1'b1;
                issue_tok.j     = j_reg;
                issue_tok.me    = me_reg;
                issue_tok.fin   = (j_reg == me_reg - IDX_W'(1));
                if (adv)
                begin
                    if (issue_tok.fin)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        j_next = j_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            j_reg     <= '0;
            me_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            j_reg     <= j_next;
            me_reg    <= me_next;
        end
    end

    // Trig values of the new line, taken at accept.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_reg <= SIN_TAB[theta_index];
            c2_reg <= COS_TAB[theta_index];
            r2_reg <= rho;
        end
    end

    // Line store: rho and angle per entry.
    logic [MEM_W-1:0] mem_rdata;

    hlpi_ram #(
        .WIDTH (MEM_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (base[IDX_W-1:0]),
        .wdata ({theta_index, rho}),
        .re    (adv),
        .raddr (j_reg),
        .rdata (mem_rdata)
    );

    // Issue register lines up with the memory read data.
    tok_t  t1_reg;
    trig_t s2_1_reg, c2_1_reg;
    rho_t  r2_1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg <= '0;
        end
        else if (adv)
        begin
            t1_reg <= issue_tok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_1_reg <= s2_reg;
            c2_1_reg <= c2_reg;
            r2_1_reg <= r2_reg;
        end
    end

    // Arithmetic front end.
    flag_t flags;
    logic [DMAG_W-1:0] den;
    logic [DIVN_W-1:0] num_x, num_y;

    hlpi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .tok_in    (t1_reg),
        .s2_in     (s2_1_reg),
        .c2_in     (c2_1_reg),
        .r2_in     (r2_1_reg),
        .mem_rho   (rho_t'(mem_rdata[RHO_W-1:0])),
        .mem_angle (mem_rdata[MEM_W-1:RHO_W]),
        .thr       (thr_reg),
        .flags     (flags),
        .den       (den),
        .num_x     (num_x),
        .num_y     (num_y)
    );

    // Dividers for x and y.
    logic [QUOT_W-1:0] qx, qy;
    logic ovx, ovy;

    hlpi_div #(.NW(DIVN_W), .DW(DMAG_W), .QW(QUOT_W)) u_div_x (
        .clk  (clk),
        .en   (adv),
        .num  (num_x),
        .den  (den),
        .quot (qx),
        .ovf  (ovx)
    );

    hlpi_div #(.NW(DIVN_W), .DW(DMAG_W), .QW(QUOT_W)) u_div_y (
        .clk  (clk),
        .en   (adv),
        .num  (num_y),
        .den  (den),
        .quot (qy),
        .ovf  (ovy)
    );

    // Control delay line matching the divider depth.
    flag_t dly_reg [QUOT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QUOT_W; i++)
            begin
                dly_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            dly_reg[0] <= flags;
            for (int i = 1; i < QUOT_W; i++)
            begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    flag_t ex;
    logic [LIM_W-1:0] xlim, ylim;
    logic surv;

    assign ex   = dly_reg[QUOT_W-1];
    assign xlim = {width_reg, FRAC_BITS'(0)};
    assign ylim = {height_reg, FRAC_BITS'(0)};

    // Bound and sign checks on the rounded quotients.
    assign surv = ex.tok.valid && ex.ok && !ovx && !ovy
                  && !(ex.neg_x && (qx != '0)) && !(ex.neg_y && (qy != '0))
                  && (qx <= QUOT_W'(xlim)) && (qy <= QUOT_W'(ylim));

    // Hold stage keeps one word back until it is known whether it is the last.
    logic h_valid_reg, h_valid_next, h_fin_reg, h_fin_next;
    logic [COORD_W-1:0] h_x_reg, h_y_reg;
    idx_t h_j_reg, h_me_reg;
    logic h_load, out_load, out_last_next, out_valid_next;
    logic [COORD_W-1:0] out_x_reg, out_y_reg;
    idx_t out_j_reg, out_me_reg;
    logic out_last_reg;

    always_comb
    begin
        h_valid_next   = h_valid_reg;
        h_fin_next     = h_fin_reg;
        h_load         = 1'b0;
        out_load       = 1'b0;
        out_last_next  = 1'b0;
        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = 1'b0;
            if (h_valid_reg && h_fin_reg)
            begin
                out_load      = 1'b1;
                out_last_next = 1'b1;
                h_valid_next  = 1'b0;
                h_fin_next    = 1'b0;
            end
            else if (surv)
            begin
                out_load     = h_valid_reg;
                h_load       = 1'b1;
                h_valid_next = 1'b1;
                h_fin_next   = ex.tok.fin;
            end
            else if (ex.tok.valid && ex.tok.fin)
            begin
                out_load      = h_valid_reg;
                out_last_next = 1'b1;
                h_valid_next  = 1'b0;
            end
            if (out_load)
            begin
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_valid_reg   <= 1'b0;
            h_fin_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            h_valid_reg   <= h_valid_next;
            h_fin_reg     <= h_fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_x_reg    <= h_x_reg;
            out_y_reg    <= h_y_reg;
            out_j_reg    <= h_j_reg;
            out_me_reg   <= h_me_reg;
            out_last_reg <= out_last_next;
        end
        if (h_load)
        begin
            h_x_reg  <= qx[COORD_W-1:0];
            h_y_reg  <= qy[COORD_W-1:0];
            h_j_reg  <= ex.tok.j;
            h_me_reg <= ex.tok.me;
        end
    end

    assign out_valid    = out_valid_reg;
    assign x_q4         = out_x_reg;
    assign y_q4         = out_y_reg;
    assign earlier_line = out_j_reg;
    assign later_line   = out_me_reg;
    assign last         = out_last_reg;

`ifndef SYNTHESIS
    // A new line is only taken while no pairs are being issued.
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == ST_IDLE))
        else $error("line taken while pairs are issuing");

    // The store count never passes capacity.
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= MAX_CNT)
        else $error("line count beyond capacity");

    // A flagged final word in the hold stage always meets an empty slot.
    a_hold_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (h_valid_reg && h_fin_reg) |-> !ex.tok.valid)
        else $error("pair arrived while final word waits");

    // Pair index stays below the new line's index while issuing.
    a_pair_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (j_reg < me_reg))
        else $error("pair index out of range");
`endif

endmodule

### test/tb_hough_line_pair_intersection_core.sv
// Self-checking testbench for the Hough line pair intersection core.
`timescale 1ns / 1ps

module tb_hough_line_pair_intersection_core;
    import hlpi_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 200;
    localparam int STORE_LINES  = 64;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [IDX_W-1:0]   early;
        logic [IDX_W-1:0]   late;
        logic               fin;
    } point_t;

    typedef struct {
        bit first;
        int r;
        int a;
        bit typed;
        int hits;
        int ex;
        int ey;
        int ee;
        int el;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic first_line;
    logic signed [RHO_W-1:0] rho;
    logic [ANGLE_W-1:0] theta_index;
    logic out_valid;
    logic out_ready;
    logic [COORD_W-1:0] x_q4;
    logic [COORD_W-1:0] y_q4;
    logic [IDX_W-1:0] earlier_line;
    logic [IDX_W-1:0] later_line;
    logic last;

    // Predictor state: trig tables, line store and register copies.
    longint sin_q15 [256];
    longint cos_q15 [256];
    longint line_rho [STORE_LINES];
    int     line_ang [STORE_LINES];
    int     line_total;
    int     width_px;
    int     height_px;
    int     thresh_q15;

    point_t point_q [$];
    point_t line_hits [$];
    int     fail_count;
    int     cycles;

    // Sampled output word.
    bit     took_word;
    point_t seen;

    dir_row_t dir_rows [14] = '{
        '{1, 100, 0, 1, 0, 0, 0, 0, 0},
        '{0, 50, 90, 1, 1, 1600, 800, 0, 1},
        '{0, 2047, 179, 0, 0, 0, 0, 0, 0},
        '{0, -2048, 1, 0, 0, 0, 0, 0, 0},
        '{0, 60, 0, 0, 0, 0, 0, 0, 0},
        '{0, 300, 255, 0, 0, 0, 0, 0, 0},
        '{0, 200, 180, 0, 0, 0, 0, 0, 0},
        '{0, 0, 45, 0, 0, 0, 0, 0, 0},
        '{0, -1, 135, 0, 0, 0, 0, 0, 0},
        '{1, 0, 0, 1, 0, 0, 0, 0, 0},
        '{0, 0, 90, 1, 1, 0, 0, 0, 1},
        '{1, 640, 0, 1, 0, 0, 0, 0, 0},
        '{0, 480, 90, 1, 1, 10240, 7680, 0, 1},
        '{0, 1000, 30, 0, 0, 0, 0, 0, 0}
    };

    hough_line_pair_intersection_core uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .first_line(first_line),
        .rho(rho),
        .theta_index(theta_index),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .x_q4(x_q4),
        .y_q4(y_q4),
        .earlier_line(earlier_line),
        .later_line(later_line),
        .last(last)
    );

    // One Horner step of the truncated Taylor series in Q30.
    function automatic longint unsigned series_term(longint unsigned x2, longint unsigned t,
                                                    longint unsigned dv);
        longint unsigned p;
        p = ((x2 * t) >> 30) / dv;
        return (p >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - p;
    endfunction

    function automatic longint q15_round(longint unsigned v);
        longint unsigned r;
        r = (v + 64'd16384) >> 15;
        return (r > 64'd32768) ? 64'sd32768 : longint'(r);
    endfunction

    // Fill the sine and cosine tables for all 256 angle codes.
    function automatic void fill_trig_tables();
        longint unsigned sin_dv [5] = '{110, 72, 42, 20, 6};
        longint unsigned cos_dv [6] = '{132, 90, 56, 30, 12, 2};
        longint unsigned x30;
        longint unsigned x2;
        longint unsigned t;
        int k;
        bit flip;
        bit mirror;
        longint s;
        longint c;
        for (int i = 0; i < 256; i++)
        begin
            k = i % ANGLE_STEPS;
            flip = ((i / ANGLE_STEPS) % 2) == 1;
            mirror = 2 * k > ANGLE_STEPS;
            if (mirror)
                k = ANGLE_STEPS - k;
            x30 = (longint'(k) * 64'd3373259426 + ANGLE_STEPS / 2) / ANGLE_STEPS;
            x2 = (x30 * x30) >> 30;
            t = 64'd1 << 30;
            for (int n = 0; n < 5; n++)
                t = series_term(x2, t, sin_dv[n]);
            s = q15_round((x30 * t) >> 30);
            t = 64'd1 << 30;
            for (int n = 0; n < 6; n++)
                t = series_term(x2, t, cos_dv[n]);
            c = q15_round(t);
            if (mirror)
                c = -c;
            if (flip)
            begin
                s = -s;
                c = -c;
            end
            sin_q15[i] = s;
            cos_q15[i] = c;
        end
    endfunction

    // Rounded quotient in Q.FRAC_BITS; true when it lies in [0, limit].
    function automatic bit coord_in_range(longint num, longint den, longint unsigned limit,
                                          output longint unsigned q);
        bit neg;
        longint unsigned mn;
        longint unsigned md;
        neg = (num < 0) != (den < 0);
        mn = (num < 0) ? -num : num;
        md = (den < 0) ? -den : den;
        q = ((mn << (15 + FRAC_BITS)) + md / 2) / md;
        if (neg && q != 0)
            return 0;
        return q <= limit;
    endfunction

    // Intersect a new line with the stored lines and store it.
    function automatic void intersect_line(bit first, logic signed [RHO_W-1:0] r,
                                           logic [ANGLE_W-1:0] a);
        longint r2;
        longint s2;
        longint c2;
        longint r1;
        longint s1;
        longint c1;
        longint d;
        longint unsigned xq;
        longint unsigned yq;
        point_t p;
        line_hits.delete();
        r2 = longint'(r);
        s2 = sin_q15[a];
        c2 = cos_q15[a];
        if (first)
            line_total = 0;
        if (line_total >= STORE_LINES)
            return;
        for (int j = 0; j < line_total; j++)
        begin
            r1 = line_rho[j];
            s1 = sin_q15[line_ang[j]];
            c1 = cos_q15[line_ang[j]];
            d = c1 * s2 - s1 * c2;
            if (d == 0 || ((d < 0) ? -d : d) < (longint'(thresh_q15) << 15))
                continue;
            if (!coord_in_range(s2 * r1 - s1 * r2, d, longint'(width_px) << FRAC_BITS, xq))
                continue;
            if (!coord_in_range(c1 * r2 - c2 * r1, d, longint'(height_px) << FRAC_BITS, yq))
                continue;
            p.x = xq[COORD_W-1:0];
            p.y = yq[COORD_W-1:0];
            p.early = j[IDX_W-1:0];
            p.late = line_total[IDX_W-1:0];
            p.fin = 0;
            line_hits = {line_hits, p};
        end
        if (line_hits.size() > 0)
            line_hits[line_hits.size() - 1].fin = 1;
        line_rho[line_total] = r2;
        line_ang[line_total] = int'(a);
        line_total++;
    endfunction

    // Clock.
    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Cycle counter and timeout.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: stretches of random stalls alternate with stretches of none.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 0;
        else if (cycles[9])
            out_ready <= ($urandom_range(0, 3) != 0);
        else if (cycles[8])
            out_ready <= ($urandom_range(0, 1) != 0);
        else
            out_ready <= 1;
    end

    // Sample the output word between edges.
    always @(negedge clk)
    begin
        took_word <= out_valid && out_ready;
        seen.x <= x_q4;
        seen.y <= y_q4;
        seen.early <= earlier_line;
        seen.late <= later_line;
        seen.fin <= last;
    end

    // Compare each accepted word with the oldest expected point.
    always @(posedge clk)
    begin
        point_t want;
        if (took_word)
        begin
            if (point_q.size() == 0)
            begin
                $error("unexpected word x_q4 %0d y_q4 %0d", seen.x, seen.y);
                fail_count++;
            end
            else
            begin
                want = point_q.pop_front();
                if (seen.x !== want.x)
                begin
                    $error("x_q4 expected %0d actual %0d", want.x, seen.x);
                    fail_count++;
                end
                if (seen.y !== want.y)
                begin
                    $error("y_q4 expected %0d actual %0d", want.y, seen.y);
                    fail_count++;
                end
                if (seen.early !== want.early)
                begin
                    $error("earlier_line expected %0d actual %0d", want.early, seen.early);
                    fail_count++;
                end
                if (seen.late !== want.late)
                begin
                    $error("later_line expected %0d actual %0d", want.late, seen.late);
                    fail_count++;
                end
                if (seen.fin !== want.fin)
                begin
                    $error("last expected %0d actual %0d", want.fin, seen.fin);
                    fail_count++;
                end
            end
        end
    end

    // Present one line word and hold it until accepted, then predict.
    task automatic send_line(bit f, logic signed [RHO_W-1:0] r, logic [ANGLE_W-1:0] a);
        bit got;
        in_valid <= 1;
        first_line <= f;
        rho <= r;
        theta_index <= a;
        do
        begin
            @(negedge clk);
            got = in_ready;
            @(posedge clk);
        end while (!got);
        intersect_line(f, r, a);
    endtask

    task automatic queue_hits();
        foreach (line_hits[i])
            point_q = {point_q, line_hits[i]};
    endtask

    // Write all three registers while the block is idle.
    task automatic write_regs(int w, int h, int t);
        cfg_we <= 1;
        cfg_index <= CFG_WIDTH;
        cfg_data <= CFG_W'(w);
        @(posedge clk);
        cfg_index <= CFG_HEIGHT;
        cfg_data <= CFG_W'(h);
        @(posedge clk);
        cfg_index <= CFG_THRESH;
        cfg_data <= CFG_W'(t);
        @(posedge clk);
        cfg_we <= 0;
        width_px = w;
        height_px = h;
        thresh_q15 = t;
    endtask

    // Hold off until every expected point has come and the pipeline is quiet.
    task automatic wait_drained();
        in_valid <= 0;
        while (point_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random lines in bursts; most are frames of plausible lines.
    task automatic random_lines(int count, int rho_max);
        int burst;
        int gap;
        bit f;
        logic signed [RHO_W-1:0] r;
        logic [ANGLE_W-1:0] a;
        burst = $urandom_range(1, 12);
        for (int n = 0; n < count; n++)
        begin
            f = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 4) == 0)
                r = RHO_W'($urandom);
            else
                r = RHO_W'($urandom_range(0, rho_max));
            if ($urandom_range(0, 9) == 0)
                a = ANGLE_W'($urandom);
            else
                a = ANGLE_W'($urandom_range(0, ANGLE_STEPS - 1));
            send_line(f, r, a);
            queue_hits();
            burst--;
            if (burst == 0)
            begin
                burst = $urandom_range(1, 12);
                gap = $urandom_range(0, 20);
                if (gap != 0)
                begin
                    in_valid <= 0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    endtask

    // Stimulus.
    initial
    begin
        point_t p;
        fail_count = 0;
        cycles = 0;
        line_total = 0;
        fill_trig_tables();
        rst_n = 0;
        cfg_we = 0;
        cfg_index = CFG_WIDTH;
        cfg_data = 0;
        in_valid = 0;
        first_line = 0;
        rho = 0;
        theta_index = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        write_regs(640, 480, 1638);

        // Directed lines at the reset bounds.
        foreach (dir_rows[i])
        begin
            send_line(dir_rows[i].first, RHO_W'(dir_rows[i].r), ANGLE_W'(dir_rows[i].a));
            if (dir_rows[i].typed)
            begin
                if (line_hits.size() != dir_rows[i].hits)
                begin
                    $error("point count expected %0d actual %0d", dir_rows[i].hits,
                           line_hits.size());
                    fail_count++;
                end
                if (dir_rows[i].hits != 0)
                begin
                    p.x = COORD_W'(dir_rows[i].ex);
                    p.y = COORD_W'(dir_rows[i].ey);
                    p.early = IDX_W'(dir_rows[i].ee);
                    p.late = IDX_W'(dir_rows[i].el);
                    p.fin = 1;
                    point_q = {point_q, p};
                end
            end
            else
                queue_hits();
        end
        wait_drained();

        // Widest bounds with no parallel rejection beyond a zero determinant.
        write_regs(2047, 2047, 0);
        random_lines(80, 2047);
        wait_drained();

        // Tightest bounds and the largest threshold.
        write_regs(1, 1, 32767);
        random_lines(40, 4);
        wait_drained();

        // A frame that overflows the store.
        write_regs(1500, 1200, 200);
        send_line(1, RHO_W'($urandom_range(0, 900)),
                  ANGLE_W'($urandom_range(0, ANGLE_STEPS - 1)));
        queue_hits();
        for (int n = 0; n < 69; n++)
        begin
            send_line(0, RHO_W'($urandom_range(0, 900)),
                      ANGLE_W'($urandom_range(0, ANGLE_STEPS - 1)));
            queue_hits();
        end
        wait_drained();

        // Random mid-range settings.
        write_regs($urandom_range(300, 1200), $urandom_range(300, 1200),
                   $urandom_range(0, 4000));
        random_lines(70, 1000);
        wait_drained();

        write_regs(640, 480, 1638);
        random_lines(70, 700);
        wait_drained();

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
